FILE: src/kctr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctr_pkg
// Types and codes shared by the keypad countdown timer relay block.
// ----------------------------------------------------------------------------
package kctr_pkg;

	localparam int unsigned VAL_W     = 10;
	localparam int unsigned CFG_IDX_W = 3;

	typedef logic [VAL_W-1:0] val_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESH_STOP  = 3'd0,
		REG_THRESH_PLUS  = 3'd1,
		REG_THRESH_MINUS = 3'd2,
		REG_THRESH_START = 3'd3,
		REG_TICKS_PER_S  = 3'd4,
		REG_MAX_SETPOINT = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_TICK   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_SET  = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_DONE = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KEY_NONE  = 3'd0,
		KEY_PLUS  = 3'd1,
		KEY_MINUS = 3'd2,
		KEY_START = 3'd3,
		KEY_STOP  = 3'd4
	} key_t;

	typedef enum logic [1:0] {
		BEEP_NONE   = 2'd0,
		BEEP_SHORT  = 2'd1,
		BEEP_TRIPLE = 2'd2
	} beep_t;

	typedef struct packed {
		val_t thresh_stop;
		val_t thresh_plus;
		val_t thresh_minus;
		val_t thresh_start;
		val_t ticks_per_second;
		val_t max_setpoint;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		val_t       target_seconds;
		val_t       elapsed_seconds;
		logic       paused;
		logic       relay_on;
		logic [1:0] beep;
		logic [2:0] key_event;
	} res_t;

	localparam val_t RST_THRESH_STOP  = 10'd861;
	localparam val_t RST_THRESH_PLUS  = 10'd581;
	localparam val_t RST_THRESH_MINUS = 10'd351;
	localparam val_t RST_THRESH_START = 10'd101;
	localparam val_t RST_TICKS_PER_S  = 10'd1000;
	localparam val_t RST_MAX_SETPOINT = 10'd999;
	localparam val_t VAL_MAX          = 10'd1023;

endpackage

FILE: src/kctr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctr_if
// Valid/ready channels of the keypad countdown timer relay block.
// ----------------------------------------------------------------------------
interface kctr_item_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [9:0] adc_level;

	modport source (output valid, command, adc_level, input ready);
	modport sink   (input valid, command, adc_level, output ready);
endinterface

interface kctr_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [9:0] target_seconds;
	logic [9:0] elapsed_seconds;
	logic       paused;
	logic       relay_on;
	logic [1:0] beep;
	logic [2:0] key_event;

	modport source (output valid, mode, target_seconds, elapsed_seconds, paused,
		relay_on, beep, key_event, input ready);
	modport sink   (input valid, mode, target_seconds, elapsed_seconds, paused,
		relay_on, beep, key_event, output ready);
endinterface

interface kctr_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [9:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/kctr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctr_cfg_regs
// Configuration register file: key thresholds, second length, setpoint limit.
// ----------------------------------------------------------------------------
module kctr_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	kctr_cfg_if.sink       cfg,
	output kctr_pkg::cfg_t regs
);
	import kctr_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.thresh_stop      <= RST_THRESH_STOP;
			regs_q.thresh_plus      <= RST_THRESH_PLUS;
			regs_q.thresh_minus     <= RST_THRESH_MINUS;
			regs_q.thresh_start     <= RST_THRESH_START;
			regs_q.ticks_per_second <= RST_TICKS_PER_S;
			regs_q.max_setpoint     <= RST_MAX_SETPOINT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				REG_THRESH_STOP:  regs_q.thresh_stop      <= cfg.data;
				REG_THRESH_PLUS:  regs_q.thresh_plus      <= cfg.data;
				REG_THRESH_MINUS: regs_q.thresh_minus     <= cfg.data;
				REG_THRESH_START: regs_q.thresh_start     <= cfg.data;
				REG_TICKS_PER_S:  regs_q.ticks_per_second <= cfg.data;
				REG_MAX_SETPOINT: regs_q.max_setpoint     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: src/kctr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctr_ctrl
// Key decode, press detection, mode machine and second counting.
// ----------------------------------------------------------------------------
module kctr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           command,
	input  kctr_pkg::val_t adc_level,
	input  kctr_pkg::cfg_t regs,
	output kctr_pkg::res_t res
);
	import kctr_pkg::*;

	mode_t mode_q, mode_n;
	val_t  setpoint_q, setpoint_n;
	val_t  elapsed_q, elapsed_n;
	logic  pause_q, pause_n;
	logic  relay_q, relay_n;
	key_t  prev_key_q, prev_key_n;
	val_t  ms_q, ms_n;
	logic  pending_q, pending_n;

	key_t        key;
	key_t        event_key;
	beep_t       beep;
	logic [10:0] ms_sum;
	val_t        elapsed_inc;

	always_comb begin
		if (adc_level > regs.thresh_stop) begin
			key = KEY_STOP;
		end else if (adc_level > regs.thresh_plus) begin
			key = KEY_PLUS;
		end else if (adc_level > regs.thresh_minus) begin
			key = KEY_MINUS;
		end else if (adc_level > regs.thresh_start) begin
			key = KEY_START;
		end else begin
			key = KEY_NONE;
		end
	end

	assign ms_sum      = {1'b0, ms_q} + 11'd1;
	assign elapsed_inc = (elapsed_q == VAL_MAX) ? elapsed_q : elapsed_q + 10'd1;

	always_comb begin
		mode_n     = mode_q;
		setpoint_n = setpoint_q;
		elapsed_n  = elapsed_q;
		pause_n    = pause_q;
		relay_n    = relay_q;
		prev_key_n = prev_key_q;
		ms_n       = ms_q;
		pending_n  = pending_q;
		event_key  = KEY_NONE;
		beep       = BEEP_NONE;
		if (cmd_t'(command) == CMD_TICK) begin
			if (ms_sum >= {1'b0, regs.ticks_per_second} || ms_sum[10]) begin
				ms_n      = '0;
				pending_n = 1'b1;
			end else begin
				ms_n = ms_sum[9:0];
			end
		end else begin
			if (key != prev_key_q) begin
				prev_key_n = key;
				event_key  = key;
				if (key == KEY_START || key == KEY_STOP) begin
					beep = BEEP_SHORT;
				end
			end
			case (mode_q)
				MODE_SET: begin
					if (event_key == KEY_PLUS && setpoint_q < regs.max_setpoint) begin
						setpoint_n = setpoint_q + 10'd1;
					end
					if (event_key == KEY_MINUS && setpoint_q != '0) begin
						setpoint_n = setpoint_q - 10'd1;
					end
					if (event_key == KEY_START && setpoint_q != '0) begin
						elapsed_n = '0;
						pause_n   = 1'b0;
						mode_n    = MODE_RUN;
					end
				end
				MODE_RUN: begin
					if (event_key == KEY_START) begin
						pause_n = ~pause_q;
					end
					if (event_key == KEY_STOP) begin
						elapsed_n = '0;
						pause_n   = 1'b0;
						mode_n    = MODE_SET;
					end else if (pending_q) begin
						pending_n = 1'b0;
						if (!pause_n) begin
							elapsed_n = elapsed_inc;
							if (elapsed_inc >= setpoint_q) begin
								relay_n = 1'b1;
								mode_n  = MODE_DONE;
								beep    = BEEP_TRIPLE;
							end
						end
					end
				end
				MODE_DONE: begin
					if (event_key != KEY_NONE) begin
						relay_n = 1'b0;
						mode_n  = MODE_SET;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.mode            = mode_n;
	assign res.target_seconds  = setpoint_n;
	assign res.elapsed_seconds = elapsed_n;
	assign res.paused          = pause_n;
	assign res.relay_on        = relay_n;
	assign res.beep            = beep;
	assign res.key_event       = event_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SET;
			setpoint_q <= '0;
			elapsed_q  <= '0;
			pause_q    <= 1'b0;
			relay_q    <= 1'b0;
			prev_key_q <= KEY_NONE;
			ms_q       <= '0;
			pending_q  <= 1'b0;
		end else if (step) begin
			mode_q     <= mode_n;
			setpoint_q <= setpoint_n;
			elapsed_q  <= elapsed_n;
			pause_q    <= pause_n;
			relay_q    <= relay_n;
			prev_key_q <= prev_key_n;
			ms_q       <= ms_n;
			pending_q  <= pending_n;
		end
	end

endmodule

FILE: src/keypad_countdown_timer_relay.sv
`timescale 1ns / 1ps
// The block takes one beat per clock cycle on the item channel, save while a
// stalled result channel holds it back, and returns one result beat per item,
// which passes through the input register and then the result register. The
// rate is set by the update of the timer state, which is applied as an item
// leaves the input register. A stalled result channel holds the result
// register and then the input register, so the item channel stops taking
// beats only while both are full.
// ----------------------------------------------------------------------------
// keypad_countdown_timer_relay
// Programmable seconds timer with an analog keypad and a relay output.
// ----------------------------------------------------------------------------
module keypad_countdown_timer_relay (
	input  logic          clk,
	input  logic          arst_n,
	kctr_item_if.sink     item,
	kctr_result_if.source result,
	kctr_cfg_if.sink      cfg
);
	import kctr_pkg::*;

	logic valid_s1;
	logic command_s1;
	val_t adc_level_s1;
	logic valid_s2;
	res_t res_s2;
	res_t res_next;
	cfg_t regs;
	logic out_free;
	logic advance;

	assign out_free   = !valid_s2 || result.ready;
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	kctr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	kctr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.command   (command_s1),
		.adc_level (adc_level_s1),
		.regs      (regs),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			command_s1   <= item.command;
			adc_level_s1 <= item.adc_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid           = valid_s2;
	assign result.mode            = res_s2.mode;
	assign result.target_seconds  = res_s2.target_seconds;
	assign result.elapsed_seconds = res_s2.elapsed_seconds;
	assign result.paused          = res_s2.paused;
	assign result.relay_on        = res_s2.relay_on;
	assign result.beep            = res_s2.beep;
	assign result.key_event       = res_s2.key_event;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the keypad countdown timer relay block against a cycle-free model
// of its timer. Keypad samples and millisecond ticks are driven on the item
// channel while the result channel is stalled at random. Every accepted item
// updates the model, and each result beat is compared with the oldest
// status the model has queued. A directed part covers key decoding at the
// thresholds, saturation of the setpoint, stale seconds and the end of a
// run. Random timer sessions then run under several register settings.
// ----------------------------------------------------------------------------
module testbench;

	import kctr_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_CYCLES = 4;

	class timer_status_scoreboard;
		val_t      thr_stop, thr_plus, thr_minus, thr_start;
		val_t      tick_limit, set_limit;
		mode_t     mode;
		val_t      target, elapsed;
		bit        paused, relay, sec_pending;
		key_t      last_key;
		val_t      ms_count;
		res_t      expected_status[$];
		int unsigned failures;
		int unsigned beats_checked;

		function new();
			thr_stop = RST_THRESH_STOP;
			thr_plus = RST_THRESH_PLUS;
			thr_minus = RST_THRESH_MINUS;
			thr_start = RST_THRESH_START;
			tick_limit = RST_TICKS_PER_S;
			set_limit = RST_MAX_SETPOINT;
			mode = MODE_SET;
			target = '0;
			elapsed = '0;
			paused = 1'b0;
			relay = 1'b0;
			sec_pending = 1'b0;
			last_key = KEY_NONE;
			ms_count = '0;
			failures = 0;
			beats_checked = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, val_t v);
			case (idx)
				REG_THRESH_STOP: thr_stop = v;
				REG_THRESH_PLUS: thr_plus = v;
				REG_THRESH_MINUS: thr_minus = v;
				REG_THRESH_START: thr_start = v;
				REG_TICKS_PER_S: tick_limit = v;
				REG_MAX_SETPOINT: set_limit = v;
				default: ;
			endcase
		endfunction

		function key_t decode(val_t lvl);
			if (lvl > thr_stop) return KEY_STOP;
			if (lvl > thr_plus) return KEY_PLUS;
			if (lvl > thr_minus) return KEY_MINUS;
			if (lvl > thr_start) return KEY_START;
			return KEY_NONE;
		endfunction

		function void advance_timer(cmd_t c, val_t lvl);
			key_t        k;
			key_t        ev;
			beep_t       bp;
			logic [10:0] cnt;
			ev = KEY_NONE;
			bp = BEEP_NONE;
			if (c == CMD_TICK) begin
				cnt = {1'b0, ms_count} + 11'd1;
				if (cnt >= {1'b0, tick_limit} || cnt > {1'b0, VAL_MAX}) begin
					cnt = '0;
					sec_pending = 1'b1;
				end
				ms_count = cnt[9:0];
			end else begin
				k = decode(lvl);
				if (k != last_key) begin
					last_key = k;
					ev = k;
					if (k == KEY_START || k == KEY_STOP) bp = BEEP_SHORT;
				end
				case (mode)
					MODE_SET: begin
						if (ev == KEY_PLUS && target < set_limit) target = target + 10'd1;
						if (ev == KEY_MINUS && target != '0) target = target - 10'd1;
						if (ev == KEY_START && target != '0) begin
							elapsed = '0;
							paused = 1'b0;
							mode = MODE_RUN;
						end
					end
					MODE_RUN: begin
						if (ev == KEY_START) paused = !paused;
						if (ev == KEY_STOP) begin
							elapsed = '0;
							paused = 1'b0;
							mode = MODE_SET;
						end else if (sec_pending) begin
							sec_pending = 1'b0;
							if (!paused) begin
								if (elapsed != VAL_MAX) elapsed = elapsed + 10'd1;
								if (elapsed >= target) begin
									relay = 1'b1;
									mode = MODE_DONE;
									bp = BEEP_TRIPLE;
								end
							end
						end
					end
					MODE_DONE: begin
						if (ev != KEY_NONE) begin
							relay = 1'b0;
							mode = MODE_SET;
						end
					end
					default: ;
				endcase
			end
			expected_status.push_back({mode, target, elapsed, paused, relay, bp, ev});
		endfunction

		function void check_status(res_t got);
			res_t exp;
			beats_checked++;
			if (expected_status.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("status beat %0d arrived with nothing expected: %p",
						beats_checked, got);
				return;
			end
			exp = expected_status.pop_front();
			if (got.mode !== exp.mode || got.target_seconds !== exp.target_seconds ||
					got.elapsed_seconds !== exp.elapsed_seconds ||
					got.paused !== exp.paused || got.relay_on !== exp.relay_on ||
					got.beep !== exp.beep || got.key_event !== exp.key_event) begin
				failures++;
				if (failures <= 10)
					$display("status beat %0d: expected %p, got %p",
						beats_checked, exp, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	kctr_item_if   item_if();
	kctr_result_if result_if();
	kctr_cfg_if    cfg_if();

	keypad_countdown_timer_relay i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	timer_status_scoreboard sb;
	bit          gaps_on;
	bit          hold_request;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (result_if.valid && result_if.ready)
				sb.check_status({result_if.mode, result_if.target_seconds,
					result_if.elapsed_seconds, result_if.paused, result_if.relay_on,
					result_if.beep, result_if.key_event});
			if (item_if.valid && item_if.ready)
				sb.advance_timer(cmd_t'(item_if.command), item_if.adc_level);
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : result_ready_driver
		int unsigned hold_left;
		hold_left = 0;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				result_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= !gaps_on || $urandom_range(0, 99) >= 13;
			end
		end
	end

	task automatic send_item(input cmd_t c, input val_t lvl);
		while (gaps_on && $urandom_range(0, 99) < 13) begin
			item_if.valid <= 1'b0;
			@(negedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.command <= c;
		item_if.adc_level <= lvl;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic sample(input val_t lvl);
		send_item(CMD_SAMPLE, lvl);
	endtask

	task automatic tick();
		send_item(CMD_TICK, val_t'($urandom_range(0, 1023)));
	endtask

	task automatic settle();
		item_if.valid <= 1'b0;
		while (sb.expected_status.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input val_t v);
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		sb.write_reg(idx, v);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic apply_setting(input val_t t_stop, input val_t t_plus, input val_t t_minus,
			input val_t t_start, input val_t tps, input val_t max_sp);
		write_reg(REG_THRESH_STOP, t_stop);
		write_reg(REG_THRESH_PLUS, t_plus);
		write_reg(REG_THRESH_MINUS, t_minus);
		write_reg(REG_THRESH_START, t_start);
		write_reg(REG_TICKS_PER_S, tps);
		write_reg(REG_MAX_SETPOINT, max_sp);
	endtask

	function automatic val_t level_for(key_t k);
		val_t lvl;
		int   n;
		lvl = val_t'($urandom_range(0, 1023));
		for (n = 0; n < 1024; n++) begin
			if (sb.decode(lvl) == k) return lvl;
			lvl = lvl + 10'd1;
		end
		return lvl;
	endfunction

	function automatic key_t pick_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		case (sb.mode)
			MODE_SET: begin
				if (sb.target > 12) begin
					if (r < 40) return KEY_MINUS;
					if (r < 55) return KEY_PLUS;
				end else begin
					if (r < 45) return KEY_PLUS;
					if (r < 60) return KEY_MINUS;
				end
				return (r < 90) ? KEY_START : KEY_STOP;
			end
			MODE_RUN: begin
				if (r < 35) return KEY_START;
				if (r < 45) return KEY_STOP;
				return (r < 75) ? KEY_PLUS : KEY_MINUS;
			end
			default: return key_t'($urandom_range(1, 4));
		endcase
	endfunction

	task automatic press(input key_t k);
		if ($urandom_range(0, 4) != 0) sample(level_for(KEY_NONE));
		sample(level_for(k));
	endtask

	task automatic operate_keypad();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			sample(val_t'($urandom_range(0, 1023)));
		else if (r < 35)
			repeat ($urandom_range(1, 6)) tick();
		else if (r < 50)
			sample(level_for(KEY_NONE));
		else
			press(pick_key());
	endtask

	task automatic run_session(input int unsigned n, input bit hold);
		int unsigned stop_at;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			if (hold && items_sent + n / 2 >= stop_at) begin
				hold_request = 1'b1;
				hold = 1'b0;
			end
			operate_keypad();
		end
	endtask

	task automatic apply_ordered_thresholds(input val_t tps, input val_t max_sp);
		apply_setting(val_t'($urandom_range(768, 1023)), val_t'($urandom_range(512, 767)),
			val_t'($urandom_range(256, 511)), val_t'($urandom_range(0, 255)), tps, max_sp);
	endtask

	initial begin
		sb = new();
		gaps_on = 1'b1;
		hold_request = 1'b0;
		items_sent = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.command = CMD_SAMPLE;
		item_if.adc_level = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_THRESH_STOP;
		cfg_if.data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sample(10'd0);
		sample(10'd1023);
		sample(10'd862);
		sample(10'd861);
		sample(10'd582);
		sample(10'd581);
		sample(10'd351);
		sample(10'd101);
		sample(10'd0);
		sample(10'd600);
		sample(10'd0);
		sample(10'd600);
		tick();
		sample(10'd102);
		sample(10'd0);
		sample(10'd1023);
		sample(10'd200);
		sample(10'd0);
		sample(10'd200);
		sample(10'd0);
		sample(10'd200);
		sample(10'd1023);
		send_item(CMD_TICK, 10'd1023);
		send_item(CMD_TICK, 10'd0);

		// A second completed outside a run is held until the next run counts it.
		write_reg(REG_TICKS_PER_S, 10'd1023);
		repeat (8) tick();
		write_reg(REG_TICKS_PER_S, 10'd5);
		tick();
		sample(10'd0);
		sample(10'd1023);
		sample(10'd200);
		sample(10'd0);
		write_reg(REG_TICKS_PER_S, 10'd1);
		tick();
		sample(10'd200);
		sample(10'd0);
		tick();
		sample(10'd200);
		sample(10'd0);
		sample(10'd600);

		write_reg(REG_MAX_SETPOINT, 10'd1);
		sample(10'd0);
		sample(10'd600);
		sample(10'd0);
		sample(10'd400);
		sample(10'd0);
		sample(10'd400);
		sample(10'd0);
		sample(10'd400);
		sample(10'd0);
		sample(10'd600);
		sample(10'd0);
		sample(10'd600);
		sample(10'd200);
		tick();
		sample(10'd0);
		sample(10'd1023);

		apply_setting(10'd1023, 10'd0, 10'd0, 10'd0, 10'd1, 10'd1);
		sample(10'd1023);
		sample(10'd0);
		sample(10'd1);
		sample(10'd0);
		write_reg(REG_THRESH_STOP, 10'd0);
		sample(10'd1);
		sample(10'd1023);
		sample(10'd0);
		apply_setting(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1, 10'd1);
		sample(10'd1023);
		sample(10'd0);

		apply_setting(RST_THRESH_STOP, RST_THRESH_PLUS, RST_THRESH_MINUS, RST_THRESH_START,
			10'd2, 10'd12);
		run_session(200, 1'b1);
		apply_ordered_thresholds(val_t'($urandom_range(1, 4)), 10'd999);
		run_session(200, 1'b0);
		apply_setting(10'd1023, 10'd700, 10'd300, 10'd0, 10'd1, 10'd1);
		gaps_on = 1'b0;
		run_session(150, 1'b0);
		gaps_on = 1'b1;
		apply_setting(10'd200, 10'd900, 10'd500, 10'd1000, 10'd3, 10'd5);
		run_session(80, 1'b0);
		apply_ordered_thresholds(val_t'($urandom_range(1, 6)),
			val_t'($urandom_range(1, 30)));
		run_session(250, 1'b1);
		apply_setting(RST_THRESH_STOP, RST_THRESH_PLUS, RST_THRESH_MINUS, RST_THRESH_START,
			RST_TICKS_PER_S, RST_MAX_SETPOINT);
		run_session(150, 1'b0);

		settle();
		repeat (10) @(posedge clk);
		if (sb.failures == 0 && sb.expected_status.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: keypad_countdown_timer_relay.f
src/kctr_pkg.sv
src/kctr_if.sv
src/kctr_cfg_regs.sv
src/kctr_ctrl.sv
src/keypad_countdown_timer_relay.sv
bench/testbench.sv
